FILE: src/polygon_node_edge_angle_test_defines.svh
// ---------------------------------------------------------------------------
// Polygon node edge angle test: assertion macros
// Shorthand for the concurrent checks on the block's stream ports.
// ---------------------------------------------------------------------------
`ifndef POLYGON_NODE_EDGE_ANGLE_TEST_DEFINES_SVH
`define POLYGON_NODE_EDGE_ANGLE_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PNEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PNEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define PNEA_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pnea_pkg.sv
// ---------------------------------------------------------------------------
// Polygon node edge angle test: shared package
// Widths, mode codes, quadrant helper and multiplier control type.
// ---------------------------------------------------------------------------
package pnea_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int OUT_TDATA_W     = 8;

  // Test selected by the tuser bit of a request.
  localparam logic MODE_CROSS    = 1'b0;
  localparam logic MODE_INTERIOR = 1'b1;

  typedef logic [1:0] quad_t;

  // Load enables of the two multiplier stages.
  typedef struct packed {
    logic load_part;
    logic load_prod;
  } mul_ctrl_t;

  // Quadrant from the sign bits of a vector, counted counter-clockwise from +x,+y.
  function automatic quad_t quad_of(input logic x_neg, input logic y_neg);
    quad_t q;
    case ({x_neg, y_neg})
      2'b00:   q = 2'd0;
      2'b10:   q = 2'd1;
      2'b11:   q = 2'd2;
      default: q = 2'd3;
    endcase
    return q;
  endfunction

endpackage

FILE: src/pnea_mul.sv
// ---------------------------------------------------------------------------
// Polygon node edge angle test: two-stage signed multiplier
// Splits both operands into halves, registers the four partial products,
// then registers their aligned sum as the exact full-width product.
// ---------------------------------------------------------------------------
module pnea_mul #(
  parameter int DW = pnea_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                   clk,
  input  pnea_pkg::mul_ctrl_t    ctrl,
  input  logic signed [DW-1:0]   a,
  input  logic signed [DW-1:0]   b,
  output logic signed [2*DW-1:0] p
);
  import pnea_pkg::*;

  localparam int H  = DW / 2;   // low half, unsigned
  localparam int HW = DW - H;   // high half, signed
  localparam int PW = 2 * DW;

  logic signed [HW-1:0]     a_hi, b_hi;
  logic signed [H:0]        a_lo, b_lo;
  logic signed [2*HW-1:0]   pp_hh;
  logic signed [HW+H:0]     pp_hl, pp_lh;
  logic        [2*H-1:0]    pp_ll;
  logic signed [PW-1:0]     sum;

  assign a_hi = a[DW-1:H];
  assign b_hi = b[DW-1:H];
  assign a_lo = {1'b0, a[H-1:0]};
  assign b_lo = {1'b0, b[H-1:0]};

  always_ff @(posedge clk) begin
    if (ctrl.load_part) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_ll <= a[H-1:0] * b[H-1:0];
    end
  end

  always_comb begin
    sum = (PW'(pp_hh) <<< (2 * H))
        + ((PW'(pp_hl) + PW'(pp_lh)) <<< H)
        + $signed({{(PW - 2 * H){1'b0}}, pp_ll});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      p <= sum;
    end
  end

endmodule

FILE: src/polygon_node_edge_angle_test.sv
// ---------------------------------------------------------------------------
// Polygon node edge angle test
// Orders edge endpoints by angle around a node and answers either an edge
// crossing test or an interior sector test for each request.
// ---------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                        tuser
//  s_*      in         node_x node_y a0_x a0_y a1_x a1_y          mode
//                      b0_x b0_y b1_x b1_y, COORD_WIDTH each
//  m_*      out        answer, padded to 8 bits                  degenerate
//
//  One request enters per cycle while s_tready is high; its result is offered
//  on m_* once it has passed through the stages below.
//  Stages: node offsets, partial products, full cross products, compare.
//  Ten split multipliers, one per cross-product term, set the depth.
//  Valid bits travel per stage; a stage loads when it is empty or its
//  successor loads, so bubbles fill during an output stall and nothing is lost.
//  rst is synchronous and clears only the valid bits.
// ---------------------------------------------------------------------------
module polygon_node_edge_angle_test #(
  parameter  int COORD_WIDTH = pnea_pkg::COORD_WIDTH_DEF,
  localparam int IN_W        = ((10 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [IN_W-1:0]                  s_tdata,  // node_x, node_y, a0_x, a0_y, a1_x,
                                                     // a1_y, b0_x, b0_y, b1_x, b1_y
  input  logic [0:0]                       s_tuser,  // mode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pnea_pkg::OUT_TDATA_W-1:0] m_tdata,  // answer, zero padding
  output logic [0:0]                       m_tuser   // degenerate
);
  import pnea_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int D  = W + 1;
  localparam int NP = 5;
  // Angle comparisons gt(p, q); points: 0 = a0, 1 = a1, 2 = b0, 3 = b1.
  localparam int PairP [NP] = '{0, 2, 2, 3, 3};
  localparam int PairQ [NP] = '{1, 0, 1, 0, 1};

  // Stage enables and valid bits.
  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;

  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: offsets from the node and degenerate detection.
  logic signed [D-1:0] dx_next [4];
  logic signed [D-1:0] dy_next [4];
  logic [3:0]          eq_node;
  logic                deg_next;
  logic [W-1:0]        node_x, node_y;

  assign node_x = s_tdata[0 +: W];
  assign node_y = s_tdata[W +: W];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [W-1:0] px, py;
      px = s_tdata[(2 * i + 2) * W +: W];
      py = s_tdata[(2 * i + 3) * W +: W];
      dx_next[i] = $signed({px[W-1], px}) - $signed({node_x[W-1], node_x});
      dy_next[i] = $signed({py[W-1], py}) - $signed({node_y[W-1], node_y});
      eq_node[i] = (px == node_x) && (py == node_y);
    end
    deg_next = eq_node[0] || eq_node[1] || eq_node[2] ||
               (eq_node[3] && (s_tuser[0] == MODE_CROSS));
  end

  logic signed [D-1:0] dx1 [4];
  logic signed [D-1:0] dy1 [4];
  logic                mode1, deg1;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        dx1[i] <= dx_next[i];
        dy1[i] <= dy_next[i];
      end
      mode1 <= s_tuser[0];
      deg1  <= deg_next;
    end
  end

  // Stage 2 and 3: products in the multipliers, quadrant outcome rides along.
  mul_ctrl_t           mctrl;
  logic signed [2*D-1:0] prod_qp [NP];  // qx * py
  logic signed [2*D-1:0] prod_pq [NP];  // qy * px
  logic [NP-1:0]       qne_next, qgt_next;

  assign mctrl.load_part = en2;
  assign mctrl.load_prod = en3;

  for (genvar k = 0; k < NP; k++) begin : g_pair
    pnea_mul #(.DW(D)) u_mul_qp (
      .clk  (clk),
      .ctrl (mctrl),
      .a    (dx1[PairQ[k]]),
      .b    (dy1[PairP[k]]),
      .p    (prod_qp[k])
    );
    pnea_mul #(.DW(D)) u_mul_pq (
      .clk  (clk),
      .ctrl (mctrl),
      .a    (dy1[PairQ[k]]),
      .b    (dx1[PairP[k]]),
      .p    (prod_pq[k])
    );

    quad_t qp, qq;
    assign qp = quad_of(dx1[PairP[k]][D-1], dy1[PairP[k]][D-1]);
    assign qq = quad_of(dx1[PairQ[k]][D-1], dy1[PairQ[k]][D-1]);
    assign qne_next[k] = (qp != qq);
    assign qgt_next[k] = (qp > qq);
  end

  logic [NP-1:0] qne2, qgt2, qne3, qgt3;
  logic          mode2, deg2, mode3, deg3;

  always_ff @(posedge clk) begin
    if (en2) begin
      qne2  <= qne_next;
      qgt2  <= qgt_next;
      mode2 <= mode1;
      deg2  <= deg1;
    end
    if (en3) begin
      qne3  <= qne2;
      qgt3  <= qgt2;
      mode3 <= mode2;
      deg3  <= deg2;
    end
  end

  // Stage 4: angle comparisons and the final predicate.
  logic [NP-1:0] gt;
  logic          swapped, btw0, btw1, answer_next;

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      gt[k] = qne3[k] ? qgt3[k] : (prod_qp[k] > prod_pq[k]);
    end
    // gt[0]: a0 beyond a1, so a1 is the low bound of the sector.
    swapped = gt[0];
    btw0 = swapped ? (gt[2] && !gt[1]) : (gt[1] && !gt[2]);
    btw1 = swapped ? (gt[4] && !gt[3]) : (gt[3] && !gt[4]);
    if (deg3) begin
      answer_next = 1'b0;
    end else if (mode3 == MODE_INTERIOR) begin
      answer_next = btw0 ^ swapped;
    end else begin
      answer_next = btw0 ^ btw1;
    end
  end

  logic answer4, deg4;

  always_ff @(posedge clk) begin
    if (en4) begin
      answer4 <= answer_next;
      deg4    <= deg3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, answer4};
  assign m_tuser  = deg4;

endmodule

FILE: src/pnea_checker.sv
// ---------------------------------------------------------------------------
// Polygon node edge angle test: port checker
// Watches the stream ports for stall behavior, reset and result sanity.
// ---------------------------------------------------------------------------
`include "polygon_node_edge_angle_test_defines.svh"

module pnea_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [pnea_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [0:0]                       m_tuser
);
  import pnea_pkg::*;

  // A stalled result stays offered.
  `PNEA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `PNEA_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // A degenerate result never claims a positive answer.
  `PNEA_ASSERT_NOW(a_deg_answer, m_tvalid && m_tuser[0], m_tdata[0] == 1'b0, "degenerate result with answer set")

  // Requests are refused only when the pipeline is full behind a stalled result.
  `PNEA_ASSERT_NOW(a_ready_stall, !s_tready, m_tvalid && !m_tready, "request refused without a stall")

  // The pipeline is empty right after reset.
  `PNEA_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid, "result offered after reset")

endmodule

bind polygon_node_edge_angle_test pnea_checker u_pnea_checker (.*);
